// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Field widths, request and status codes, and the decision record shared by
// the page frame allocator and its update logic.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int KIND_W = 3;
  localparam int PAGE_W = 15;
  localparam int AMT_W  = 17;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_COUNT = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic              stack_empty;
    logic              stack_full;
    logic              page_oob;
    logic              below_first;
  } pfa_flags_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] result_page;
    logic [CNT_W-1:0]  count;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              push;
    logic              pop;
  } pfa_decision_t;

endpackage

// ===== rtl/pfa_decide.sv =====
// ----------------------------------------------------------------------------
// pfa_decide
// Works out the result, the count write-back and the stack move of one
// transaction from the count read out of memory.
// ----------------------------------------------------------------------------
module pfa_decide (
  input  logic [pfa_pkg::KIND_W-1:0] kind,
  input  logic [pfa_pkg::AMT_W-1:0]  amount,
  input  logic [pfa_pkg::PAGE_W-1:0] top_page,
  input  logic [pfa_pkg::CNT_W-1:0]  cnt,
  input  pfa_pkg::pfa_flags_t        flags,
  output pfa_pkg::pfa_decision_t     dec
);

  logic [pfa_pkg::CNT_W+1:0] sum;

  assign sum = {2'b00, cnt} + {amount[pfa_pkg::AMT_W-1], amount};

  always_comb begin
    dec = '0;
    if (kind == pfa_pkg::KIND_ALLOC) begin
      if (flags.stack_empty) begin
        dec.status = pfa_pkg::ST_EMPTY;
      end else if (cnt == pfa_pkg::COUNT_MAX) begin
        dec.status = pfa_pkg::ST_COUNT;
        dec.count  = cnt;
      end else begin
        dec.status      = pfa_pkg::ST_OK;
        dec.result_page = top_page;
        dec.count       = cnt + 16'd1;
        dec.cnt_we      = 1'b1;
        dec.cnt_wdata   = cnt + 16'd1;
        dec.pop         = 1'b1;
      end
    end else if (flags.page_oob) begin
      dec.status = pfa_pkg::ST_RANGE;
    end else begin
      case (kind)
        pfa_pkg::KIND_FREE: begin
          if (flags.below_first) begin
            dec.status = pfa_pkg::ST_RANGE;
          end else if (cnt > 16'd1) begin
            dec.count     = cnt - 16'd1;
            dec.cnt_we    = 1'b1;
            dec.cnt_wdata = cnt - 16'd1;
          end else if (flags.stack_full) begin
            dec.status = pfa_pkg::ST_FULL;
            dec.count  = cnt;
          end else begin
            dec.cnt_we = 1'b1;
            dec.push   = 1'b1;
          end
        end
        pfa_pkg::KIND_ADD: begin
          if (sum[pfa_pkg::CNT_W+1:pfa_pkg::CNT_W] != 2'b00) begin
            dec.status = pfa_pkg::ST_COUNT;
            dec.count  = cnt;
          end else begin
            dec.count     = sum[pfa_pkg::CNT_W-1:0];
            dec.cnt_we    = 1'b1;
            dec.cnt_wdata = sum[pfa_pkg::CNT_W-1:0];
          end
        end
        pfa_pkg::KIND_SET: begin
          if (amount[pfa_pkg::AMT_W-1]) begin
            dec.status = pfa_pkg::ST_COUNT;
            dec.count  = cnt;
          end else begin
            dec.count     = amount[pfa_pkg::CNT_W-1:0];
            dec.cnt_we    = 1'b1;
            dec.cnt_wdata = amount[pfa_pkg::CNT_W-1:0];
          end
        end
        default: begin
          dec.count = cnt;
        end
      endcase
    end
  end

endmodule

// ===== rtl/page_frame_allocator_refcount.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page allocator: last-in-first-out free stack and per-page reference counts,
// both held in single-port-write synchronous memories.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready (kind, page, amount); each transaction
// gives exactly one result on out_valid/out_ready (status, result_page,
// count). cfg_valid/cfg_ready writes first_usable_page; cfg_ready is always
// high. The user must write the register only while no request is in flight;
// the block itself does not enforce it. After reset a clearing pass writes
// zero to every reference count, one entry a cycle, with in_ready low; the
// stack is empty and first_usable_page is 0.
// Steps: free, add, set and read read the count memory; allocate reads the
// stack, then the count of the popped page. One request is in flight at a
// time: no new request is taken until the current one has finished and its
// count is written back to the count memory.
// The output register holds a result until out_ready; while it is full
// the finished request waits and no new request is taken.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
  parameter int NUM_PAGES = 32768
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfa_pkg::KIND_W-1:0]  in_kind,
  input  logic [pfa_pkg::PAGE_W-1:0]  in_page,
  input  logic [pfa_pkg::AMT_W-1:0]   in_amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pfa_pkg::STAT_W-1:0]  out_status,
  output logic [pfa_pkg::PAGE_W-1:0]  out_result_page,
  output logic [pfa_pkg::CNT_W-1:0]   out_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pfa_pkg::PAGE_W-1:0]  cfg_data
);

  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PAGES - 1);
  localparam logic [DW-1:0] FULL_DEPTH = DW'(NUM_PAGES);

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_STK, S_CNT} state_t;

  state_t                      state_r;
  logic [AW-1:0]               clr_idx_r;
  logic [DW-1:0]               depth_r;
  logic [pfa_pkg::PAGE_W-1:0]  first_r;
  logic [pfa_pkg::KIND_W-1:0]  kind_r;
  logic [pfa_pkg::PAGE_W-1:0]  page_r;
  logic [pfa_pkg::AMT_W-1:0]   amount_r;
  logic                        oob_r;
  logic [pfa_pkg::PAGE_W-1:0]  top_r;
  logic                        out_valid_r;
  logic [pfa_pkg::STAT_W-1:0]  out_status_r;
  logic [pfa_pkg::PAGE_W-1:0]  out_page_r;
  logic [pfa_pkg::CNT_W-1:0]   out_count_r;

  logic [pfa_pkg::PAGE_W-1:0]  stk_mem [NUM_PAGES];
  logic [pfa_pkg::CNT_W-1:0]   cnt_mem [NUM_PAGES];
  logic [pfa_pkg::PAGE_W-1:0]  stk_q;
  logic [pfa_pkg::CNT_W-1:0]   cnt_q;

  logic                        in_acc;
  logic                        finish;
  logic [DW-1:0]               depth_m1;
  logic                        stk_re;
  logic                        cnt_re;
  logic [AW-1:0]               cnt_raddr;
  logic                        cnt_we;
  logic [AW-1:0]               cnt_waddr;
  logic [pfa_pkg::CNT_W-1:0]   cnt_wdata;
  pfa_pkg::pfa_flags_t         flags;
  pfa_pkg::pfa_decision_t      dec;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign finish    = (state_r == S_CNT) && (!out_valid_r || out_ready);
  assign depth_m1  = depth_r - DW'(1);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_page = out_page_r;
  assign out_count       = out_count_r;

  assign flags.stack_empty = (depth_r == '0);
  assign flags.stack_full  = (depth_r == FULL_DEPTH);
  assign flags.page_oob    = oob_r;
  assign flags.below_first = (page_r < first_r);

  pfa_decide u_decide (
    .kind     (kind_r),
    .amount   (amount_r),
    .top_page (top_r),
    .cnt      (cnt_q),
    .flags    (flags),
    .dec      (dec)
  );

  assign stk_re    = in_acc && (in_kind == pfa_pkg::KIND_ALLOC);
  assign cnt_re    = (in_acc && (in_kind != pfa_pkg::KIND_ALLOC)) || (state_r == S_STK);
  assign cnt_raddr = (state_r == S_STK) ? AW'(stk_q) : AW'(in_page);

  always_comb begin
    if (state_r == S_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx_r;
      cnt_wdata = '0;
    end else begin
      cnt_we    = finish && dec.cnt_we;
      cnt_waddr = (kind_r == pfa_pkg::KIND_ALLOC) ? AW'(top_r) : AW'(page_r);
      cnt_wdata = dec.cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && dec.push) begin
      stk_mem[depth_r[AW-1:0]] <= page_r;
    end
    if (stk_re) begin
      stk_q <= stk_mem[depth_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      depth_r     <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        first_r <= cfg_data;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_idx_r <= clr_idx_r + AW'(1);
          if (clr_idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_r   <= in_kind;
            page_r   <= in_page;
            amount_r <= in_amount;
            oob_r    <= (32'(in_page) >= 32'(NUM_PAGES));
            state_r  <= (in_kind == pfa_pkg::KIND_ALLOC) ? S_STK : S_CNT;
          end
        end
        S_STK: begin
          top_r   <= stk_q;
          state_r <= S_CNT;
        end
        S_CNT: begin
          if (finish) begin
            out_status_r <= dec.status;
            out_page_r   <= dec.result_page;
            out_count_r  <= dec.count;
            if (dec.push) begin
              depth_r <= depth_r + DW'(1);
            end else if (dec.pop) begin
              depth_r <= depth_m1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page frame allocator with reference counts.
// A queue of requests feeds a bursty driver. Each accepted transaction runs
// through a shadow allocator: a free stack, a count per page and the first
// usable page. The shadow result is queued, and the monitor compares every
// reply with it field by field. Phases cover directed corner cases and random
// traffic under several first-usable-page settings. The receiver stalls on
// its own pattern and once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_PAGES = 32768;
  localparam logic [pfa_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [pfa_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [pfa_pkg::PAGE_W-1:0] PAGE_TOP = '1;
  localparam logic [pfa_pkg::PAGE_W-1:0] SHARED_PAGE = 15'd9;
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 330;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TIMEOUT_NS = 30_000_000;

  typedef struct packed {
    logic [pfa_pkg::KIND_W-1:0] kind;
    logic [pfa_pkg::PAGE_W-1:0] page;
    logic [pfa_pkg::AMT_W-1:0]  amount;
  } page_request_t;

  typedef struct packed {
    logic [pfa_pkg::STAT_W-1:0] status;
    logic [pfa_pkg::PAGE_W-1:0] result_page;
    logic [pfa_pkg::CNT_W-1:0]  count;
  } page_reply_t;

  typedef enum logic [1:0] {RX_FREE_RUN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic [pfa_pkg::KIND_W-1:0] in_kind = '0;
  logic [pfa_pkg::PAGE_W-1:0] in_page = '0;
  logic [pfa_pkg::AMT_W-1:0]  in_amount = '0;
  logic                       out_ready = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [pfa_pkg::PAGE_W-1:0] cfg_data = '0;
  logic                       in_ready;
  logic                       out_valid;
  logic [pfa_pkg::STAT_W-1:0] out_status;
  logic [pfa_pkg::PAGE_W-1:0] out_result_page;
  logic [pfa_pkg::CNT_W-1:0]  out_count;
  logic                       cfg_ready;

  page_request_t requests_todo[$];
  page_reply_t   replies_due[$];

  logic [pfa_pkg::PAGE_W-1:0] shadow_stack [NUM_PAGES];
  logic [pfa_pkg::CNT_W-1:0]  shadow_refs [NUM_PAGES];
  int                         shadow_depth = 0;
  logic [pfa_pkg::PAGE_W-1:0] shadow_first_usable = '0;

  bit       req_taken = 1'b0;
  bit       pressure_armed = 1'b0;
  bit       hold_off = 1'b0;
  int       mismatches = 0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       stall_left = 0;
  int       ready_tick = 0;
  rx_mode_t stall_mode = RX_FREE_RUN;

  page_frame_allocator_refcount u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_page         (in_page),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_page (out_result_page),
    .out_count       (out_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic page_reply_t page_op_outcome(page_request_t req);
    page_reply_t                res;
    logic [pfa_pkg::PAGE_W-1:0] top;
    logic [pfa_pkg::CNT_W-1:0]  cur;
    int                         amt;
    int                         sum;
    res = '0;
    amt = $signed(req.amount);
    cur = shadow_refs[req.page];
    case (req.kind)
      pfa_pkg::KIND_ALLOC: begin
        if (shadow_depth == 0) begin
          res.status = pfa_pkg::ST_EMPTY;
        end else begin
          top = shadow_stack[shadow_depth - 1];
          if (shadow_refs[top] == pfa_pkg::COUNT_MAX) begin
            res.status = pfa_pkg::ST_COUNT;
            res.count = pfa_pkg::COUNT_MAX;
          end else begin
            shadow_depth--;
            shadow_refs[top] = shadow_refs[top] + 16'd1;
            res.status = pfa_pkg::ST_OK;
            res.result_page = top;
            res.count = shadow_refs[top];
          end
        end
      end
      pfa_pkg::KIND_FREE: begin
        if (req.page < shadow_first_usable) begin
          res.status = pfa_pkg::ST_RANGE;
        end else if (cur > 16'd1) begin
          shadow_refs[req.page] = cur - 16'd1;
          res.status = pfa_pkg::ST_OK;
          res.count = cur - 16'd1;
        end else if (shadow_depth >= NUM_PAGES) begin
          res.status = pfa_pkg::ST_FULL;
          res.count = cur;
        end else begin
          shadow_stack[shadow_depth] = req.page;
          shadow_depth++;
          shadow_refs[req.page] = '0;
          res.status = pfa_pkg::ST_OK;
        end
      end
      pfa_pkg::KIND_ADD: begin
        sum = int'(cur) + amt;
        if (sum < 0 || sum > int'(pfa_pkg::COUNT_MAX)) begin
          res.status = pfa_pkg::ST_COUNT;
          res.count = cur;
        end else begin
          shadow_refs[req.page] = sum[pfa_pkg::CNT_W-1:0];
          res.status = pfa_pkg::ST_OK;
          res.count = sum[pfa_pkg::CNT_W-1:0];
        end
      end
      pfa_pkg::KIND_SET: begin
        if (amt < 0 || amt > int'(pfa_pkg::COUNT_MAX)) begin
          res.status = pfa_pkg::ST_COUNT;
          res.count = cur;
        end else begin
          shadow_refs[req.page] = amt[pfa_pkg::CNT_W-1:0];
          res.status = pfa_pkg::ST_OK;
          res.count = amt[pfa_pkg::CNT_W-1:0];
        end
      end
      default: begin
        res.status = pfa_pkg::ST_OK;
        res.count = cur;
      end
    endcase
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] expv, logic [31:0] actv);
    mismatches++;
    $display("%0t ns: %s expected %0d, got %0d", $time, field, expv, actv);
  endtask

  task automatic queue_request(logic [pfa_pkg::KIND_W-1:0] kind,
                               logic [pfa_pkg::PAGE_W-1:0] page,
                               logic [pfa_pkg::AMT_W-1:0] amount);
    page_request_t req;
    req.kind = kind;
    req.page = page;
    req.amount = amount;
    requests_todo.push_back(req);
  endtask

  task automatic queue_random(int count, logic [pfa_pkg::PAGE_W-1:0] first_usable);
    int                         base;
    int                         pick;
    int                         roll;
    logic [pfa_pkg::KIND_W-1:0] kind;
    logic [pfa_pkg::PAGE_W-1:0] page;
    logic [pfa_pkg::AMT_W-1:0]  amount;
    base = int'(first_usable);
    if (base > int'(PAGE_TOP) - POOL_SIZE + 1) begin
      base = int'(PAGE_TOP) - POOL_SIZE + 1;
    end
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        kind = pfa_pkg::KIND_ALLOC;
      end else if (pick < 60) begin
        kind = pfa_pkg::KIND_FREE;
      end else if (pick < 75) begin
        kind = pfa_pkg::KIND_ADD;
      end else if (pick < 85) begin
        kind = pfa_pkg::KIND_SET;
      end else if (pick < 95) begin
        kind = pfa_pkg::KIND_READ;
      end else begin
        roll = $urandom_range(int'(KIND_SPARE_LO), int'(KIND_SPARE_HI));
        kind = roll[pfa_pkg::KIND_W-1:0];
      end
      if ($urandom_range(0, 9) < 7) begin
        roll = base + int'($urandom_range(0, POOL_SIZE - 1));
      end else begin
        roll = $urandom_range(0, int'(PAGE_TOP));
      end
      page = roll[pfa_pkg::PAGE_W-1:0];
      pick = $urandom_range(0, 9);
      if (kind == pfa_pkg::KIND_ADD && pick < 7) begin
        roll = int'($urandom_range(0, 8)) - 4;
      end else if (kind == pfa_pkg::KIND_SET && pick < 6) begin
        roll = $urandom_range(0, 3);
      end else if (kind == pfa_pkg::KIND_SET && pick < 8) begin
        roll = int'(pfa_pkg::COUNT_MAX) - int'($urandom_range(0, 1));
      end else begin
        roll = $urandom_range(0, 17'h1FFFF);
      end
      amount = roll[pfa_pkg::AMT_W-1:0];
      queue_request(kind, page, amount);
    end
  endtask

  task automatic write_first_usable(logic [pfa_pkg::PAGE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (requests_todo.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver: hold until accepted, then advance in bursts
  always @(negedge clk) begin
    page_request_t req;
    if (rst_n && !(in_valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_todo.size() > 0) begin
        req = requests_todo.pop_front();
        in_kind <= req.kind;
        in_page <= req.page;
        in_amount <= req.amount;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    logic want;
    if (rst_n) begin
      if (stall_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      ready_tick++;
      case (stall_mode)
        RX_FREE_RUN: want = 1'b1;
        RX_COIN:     want = ($urandom_range(0, 1) == 1);
        RX_SPARSE:   want = (ready_tick % 4 == 0);
        default:     want = ($urandom_range(0, 7) != 0);
      endcase
      out_ready <= want && !hold_off;
    end
  end

  initial begin
    wait (pressure_armed);
    repeat (40) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    page_request_t req;
    page_reply_t   want;
    req_taken = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        shadow_first_usable = cfg_data;
      end
      if (req_taken) begin
        req.kind = in_kind;
        req.page = in_page;
        req.amount = in_amount;
        replies_due.push_back(page_op_outcome(req));
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected reply status %0d page %0d count %0d", $time,
                   out_status, out_result_page, out_count);
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            report_field("status", 32'(want.status), 32'(out_status));
          end
          if (out_result_page !== want.result_page) begin
            report_field("result_page", 32'(want.result_page), 32'(out_result_page));
          end
          if (out_count !== want.count) begin
            report_field("count", 32'(want.count), 32'(out_count));
          end
        end
      end
    end
  end

  initial begin
    logic [pfa_pkg::PAGE_W-1:0] cfg;
    int                         roll;
    for (int p = 0; p < NUM_PAGES; p++) begin
      shadow_refs[p] = '0;
      shadow_stack[p] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_first_usable(15'd16);
    queue_request(pfa_pkg::KIND_ALLOC, '0, '0);
    queue_request(pfa_pkg::KIND_READ, PAGE_TOP, 17'h1FFFF);
    queue_request(pfa_pkg::KIND_FREE, 15'd3, '0);
    queue_request(pfa_pkg::KIND_FREE, 15'd16, '0);
    queue_request(pfa_pkg::KIND_FREE, PAGE_TOP, '0);
    queue_request(pfa_pkg::KIND_ADD, 15'd20, 17'd65535);
    queue_request(pfa_pkg::KIND_ADD, 15'd20, 17'd1);
    queue_request(pfa_pkg::KIND_ADD, 15'd20, 17'h10000);
    queue_request(pfa_pkg::KIND_ADD, 15'd20, 17'h10001);
    queue_request(pfa_pkg::KIND_SET, 15'd21, 17'd65535);
    queue_request(pfa_pkg::KIND_SET, 15'd21, 17'h1FFFF);
    queue_request(pfa_pkg::KIND_SET, 15'd21, 17'h10000);
    queue_request(pfa_pkg::KIND_SET, PAGE_TOP, 17'd65535);
    queue_request(pfa_pkg::KIND_ALLOC, '0, '0);
    queue_request(pfa_pkg::KIND_SET, PAGE_TOP, 17'd2);
    queue_request(pfa_pkg::KIND_ALLOC, '0, '0);
    repeat (3) queue_request(pfa_pkg::KIND_FREE, PAGE_TOP, '0);
    repeat (3) queue_request(pfa_pkg::KIND_ALLOC, '0, '0);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      queue_request(k[pfa_pkg::KIND_W-1:0], 15'd21, '0);
    end
    repeat (2) queue_request(pfa_pkg::KIND_FREE, 15'd16, '0);
    repeat (2) queue_request(pfa_pkg::KIND_ALLOC, '0, '0);
    queue_request(pfa_pkg::KIND_SET, SHARED_PAGE, 17'd2);
    repeat (2) queue_request(pfa_pkg::KIND_FREE, SHARED_PAGE, '0);
    queue_request(pfa_pkg::KIND_ALLOC, '0, '0);
    queue_request(pfa_pkg::KIND_FREE, SHARED_PAGE, '0);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       roll = 0;
        1:       roll = int'(PAGE_TOP);
        2:       roll = $urandom_range(1, 64);
        default: roll = $urandom_range(0, int'(PAGE_TOP));
      endcase
      cfg = roll[pfa_pkg::PAGE_W-1:0];
      write_first_usable(cfg);
      queue_random(ITEMS_PER_PHASE, cfg);
      pressure_armed = 1'b1;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pfa_pkg.sv
rtl/pfa_decide.sv
rtl/page_frame_allocator_refcount.sv
tb/sv/testbench.sv
